@@ sv/kwsc_pkg.sv @@
// ----------------------------------------------------------------------------
// kwsc_pkg
// Shared types and constants for the keyword substitution cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package kwsc_pkg;

  // Field widths
  localparam int ACT_W  = 3;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 5;

  // First byte of each letter range
  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 3'd0,
    ACT_KEY   = 3'd1,
    ACT_DONE  = 3'd2,
    ACT_ENC   = 3'd3,
    ACT_DEC   = 3'd4
  } act_e;

  // Control of one mapping table
  typedef struct packed {
    logic clr;  // return every entry to identity
    logic we;   // write one entry
  } tbl_ctl_t;

endpackage

`default_nettype wire

@@ sv/keyword_substitution_cipher.sv @@
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword monoalphabetic substitution cipher, one action on one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries action_i and char_in_i.
//   Output channel (out_valid_o / out_stall_i) carries char_out_o and
//   status_o; every input transfer yields exactly one output transfer.
//   Actions: clear key, add key letter, key done, encrypt, decrypt.
// Sequencing (one item at a time; no new input until the result is loaded out):
//   clear, key letter, non-letter text, unknown action, rejected key done:
//   straight to the result stage. Encrypt/decrypt of a letter: one forward or
//   inverse table read, then the result. Accepted key done: fill of the
//   forward table (one candidate letter per cycle), then the inverse table is
//   rebuilt from the forward table read port, then the result.
// Reset:
//   Both tables read as identity (per-entry valid bits cleared), key state
//   cleared. No clearing pass; the block is ready right after reset.
// Stall:
//   A finished result waits in the output register; the next item may be
//   accepted meanwhile and its result is held until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_substitution_cipher #(
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [kwsc_pkg::ACT_W-1:0]  action_i,
  input  wire logic [kwsc_pkg::CHAR_W-1:0] char_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [kwsc_pkg::CHAR_W-1:0] char_out_o,
  output logic                             status_o
);

  localparam int AW       = $clog2(ALPHABET_SIZE);
  localparam int KLW      = $clog2(ALPHABET_SIZE + 1);
  localparam int UpperEnd = 'h41 + ALPHABET_SIZE;
  localparam int LowerEnd = 'h61 + ALPHABET_SIZE;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_FILL,
    S_INV,
    S_INV_LAST,
    S_RESP
  } state_e;

  state_e                       state_q, state_d;
  logic [ALPHABET_SIZE-1:0]     used_q, used_d;
  logic [KLW-1:0]               klen_q, klen_d;
  logic                         bad_q, bad_d;
  logic [KLW-1:0]               nxt_q, nxt_d;
  logic [AW-1:0]                cnt_q, cnt_d;
  logic                         pend_q, pend_d;
  logic [AW-1:0]                widx_q, widx_d;
  logic                         lower_q, lower_d;
  logic                         dec_q, dec_d;
  logic [kwsc_pkg::CHAR_W-1:0]  res_char_q, res_char_d;
  logic                         res_stat_q, res_stat_d;
  logic                         out_valid_q, out_valid_d;
  logic [kwsc_pkg::CHAR_W-1:0]  char_out_q, char_out_d;
  logic                         status_q, status_d;

  logic                         accept;
  logic                         is_upper, is_lower, is_letter;
  logic [kwsc_pkg::CHAR_W-1:0]  c_off;
  logic [AW-1:0]                c_idx;
  logic                         out_free;
  logic [kwsc_pkg::CHAR_W-1:0]  base;
  logic [kwsc_pkg::IDX_W-1:0]   lut_val;

  kwsc_pkg::tbl_ctl_t           fwd_ctl, inv_ctl;
  logic [AW-1:0]                fwd_waddr, fwd_raddr, inv_waddr, inv_raddr;
  logic [kwsc_pkg::IDX_W-1:0]   fwd_wdata, inv_wdata, fwd_rdata, inv_rdata;

  // forward and inverse mapping tables
  kwsc_table #(.DEPTH(ALPHABET_SIZE)) u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fwd_ctl),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .raddr_i (fwd_raddr),
    .rdata_o (fwd_rdata)
  );

  kwsc_table #(.DEPTH(ALPHABET_SIZE)) u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (inv_ctl),
    .waddr_i (inv_waddr),
    .wdata_i (inv_wdata),
    .raddr_i (inv_raddr),
    .rdata_o (inv_rdata)
  );

  // input byte classification
  assign is_upper  = (char_in_i >= kwsc_pkg::UPPER_FIRST) &&
                     (char_in_i < kwsc_pkg::CHAR_W'(UpperEnd));
  assign is_lower  = (char_in_i >= kwsc_pkg::LOWER_FIRST) &&
                     (char_in_i < kwsc_pkg::CHAR_W'(LowerEnd));
  assign is_letter = is_upper || is_lower;
  assign c_off     = is_lower ? (char_in_i - kwsc_pkg::LOWER_FIRST)
                              : (char_in_i - kwsc_pkg::UPPER_FIRST);
  assign c_idx     = c_off[AW-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // letter lookup result
  assign lut_val = dec_q ? inv_rdata : fwd_rdata;
  assign base    = lower_q ? kwsc_pkg::LOWER_FIRST : kwsc_pkg::UPPER_FIRST;

  // sequencer: key entry, fill, inverse rebuild, lookup
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    klen_d      = klen_q;
    bad_d       = bad_q;
    nxt_d       = nxt_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    widx_d      = widx_q;
    lower_d     = lower_q;
    dec_d       = dec_q;
    res_char_d  = res_char_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_out_d  = char_out_q;
    status_d    = status_q;

    fwd_ctl   = '0;
    inv_ctl   = '0;
    fwd_waddr = klen_q[AW-1:0];
    fwd_wdata = kwsc_pkg::IDX_W'(c_idx);
    fwd_raddr = c_idx;
    inv_waddr = fwd_rdata[AW-1:0];
    inv_wdata = kwsc_pkg::IDX_W'(widx_q);
    inv_raddr = c_idx;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_char_d = char_in_i;
          res_stat_d = 1'b0;
          lower_d    = is_lower;
          state_d    = S_RESP;
          case (action_i)
            kwsc_pkg::ACT_CLEAR: begin
              used_d = '0;
              klen_d = '0;
              bad_d  = 1'b0;
            end
            kwsc_pkg::ACT_KEY: begin
              if (!is_letter) begin
                bad_d = 1'b1;
              end else if (!used_q[c_idx]) begin
                used_d[c_idx] = 1'b1;
                if (klen_q < KLW'(ALPHABET_SIZE)) begin
                  fwd_ctl.we = 1'b1;
                  klen_d     = klen_q + 1'b1;
                end
              end
            end
            kwsc_pkg::ACT_DONE: begin
              if (bad_q) begin
                res_stat_d  = 1'b1;
                fwd_ctl.clr = 1'b1;
                inv_ctl.clr = 1'b1;
              end else begin
                nxt_d   = '0;
                state_d = S_FILL;
              end
            end
            kwsc_pkg::ACT_ENC, kwsc_pkg::ACT_DEC: begin
              dec_d = (action_i == kwsc_pkg::ACT_DEC);
              if (is_letter) begin
                state_d = S_LOOK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_LOOK: begin
        res_char_d = base + kwsc_pkg::CHAR_W'(lut_val);
        state_d    = S_RESP;
      end

      // one candidate letter per cycle, ascending
      S_FILL: begin
        if ((klen_q == KLW'(ALPHABET_SIZE)) || (nxt_q == KLW'(ALPHABET_SIZE))) begin
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = S_INV;
        end else begin
          nxt_d = nxt_q + 1'b1;
          if (!used_q[nxt_q[AW-1:0]]) begin
            used_d[nxt_q[AW-1:0]] = 1'b1;
            fwd_ctl.we = 1'b1;
            fwd_wdata  = kwsc_pkg::IDX_W'(nxt_q[AW-1:0]);
            klen_d     = klen_q + 1'b1;
          end
        end
      end

      // read forward entry i, next cycle write inverse[forward[i]] = i
      S_INV: begin
        fwd_raddr = cnt_q;
        pend_d    = 1'b1;
        widx_d    = cnt_q;
        if (pend_q && (fwd_rdata < kwsc_pkg::IDX_W'(ALPHABET_SIZE))) begin
          inv_ctl.we = 1'b1;
        end
        if (cnt_q == AW'(ALPHABET_SIZE - 1)) begin
          state_d = S_INV_LAST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_INV_LAST: begin
        if (pend_q && (fwd_rdata < kwsc_pkg::IDX_W'(ALPHABET_SIZE))) begin
          inv_ctl.we = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = S_RESP;
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_out_d  = res_char_q;
          status_d    = res_stat_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      klen_q      <= '0;
      bad_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      klen_q      <= klen_d;
      bad_q       <= bad_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nxt_q      <= nxt_d;
    cnt_q      <= cnt_d;
    widx_q     <= widx_d;
    lower_q    <= lower_d;
    dec_q      <= dec_d;
    res_char_q <= res_char_d;
    res_stat_q <= res_stat_d;
    char_out_q <= char_out_d;
    status_q   <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;
  assign status_o    = status_q;

  // key length always equals the number of letters marked used
  a_klen_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    klen_q == KLW'($countones(used_q)))
    else $error("key length out of step with used letters");

  // a new result appears only from the result stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("output loaded outside result stage");

  // the last inverse write always has a pending forward read
  a_inv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INV_LAST |-> pend_q)
    else $error("inverse rebuild lost its last entry");

  // a table is never cleared and written in the same cycle
  a_clr_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_ctl.clr && fwd_ctl.we) && !(inv_ctl.clr && inv_ctl.we))
    else $error("table clear collides with write");

  // fill only runs while the key is good
  a_fill_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> !bad_q)
    else $error("fill started on rejected key");

endmodule

`default_nettype wire

@@ sv/kwsc_ram.sv @@
// ----------------------------------------------------------------------------
// kwsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kwsc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/kwsc_table.sv @@
// ----------------------------------------------------------------------------
// kwsc_table
// Mapping table: RAM plus one valid bit per entry. An entry never written
// since the last clear reads as its own index (identity mapping).
// ----------------------------------------------------------------------------
`default_nettype none

module kwsc_table #(
  parameter int DEPTH = 26
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire kwsc_pkg::tbl_ctl_t        ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire logic [kwsc_pkg::IDX_W-1:0] wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr_i,
  output logic      [kwsc_pkg::IDX_W-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);

  logic [DEPTH-1:0]            vld_q;
  logic                        vld_rd_q;
  logic [AW-1:0]               raddr_q;
  logic [kwsc_pkg::IDX_W-1:0]  ram_rdata;

  kwsc_ram #(
    .WIDTH (kwsc_pkg::IDX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.we),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // valid bits: clear all at once, set on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= vld_q[raddr_i];
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.we) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  // read address follows the RAM read latency
  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_i;
  end

  assign rdata_o = vld_rd_q ? ram_rdata : kwsc_pkg::IDX_W'(raddr_q);

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the keyword substitution cipher.
// ----------------------------------------------------------------------------
// A queue of pending transfers feeds a clocked driver. Every accepted input
// runs through a cycle-free model of the key state and both mapping tables,
// and the predicted byte and status go into a queue. A clocked monitor
// compares each output transfer with the oldest prediction.
// Stimulus: a directed opening (pass-through bytes, unknown actions, key entry
// with repeats, text during entry, repeated key done, bad key), then random
// key sessions with text, mixed with some raw noise.
// Both sides idle at random. The receiver holds off once for a long stretch,
// and the sender drains the block completely between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int ALPHA      = 26;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [kwsc_pkg::ACT_W-1:0]  act;
    logic [kwsc_pkg::CHAR_W-1:0] ch;
  } cipher_item_t;

  typedef struct packed {
    logic [kwsc_pkg::CHAR_W-1:0] ch;
    logic                        st;
  } cipher_res_t;

  // DUT connections
  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic [kwsc_pkg::ACT_W-1:0]  action    = '0;
  logic [kwsc_pkg::CHAR_W-1:0] char_in   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [kwsc_pkg::CHAR_W-1:0] char_out;
  logic                        status;

  // Model of the key state
  logic [kwsc_pkg::IDX_W-1:0] fwd_map [ALPHA];
  logic [kwsc_pkg::IDX_W-1:0] inv_map [ALPHA];
  logic [ALPHA-1:0]           taken;
  int                         key_len;
  bit                         key_broken;

  // Pending transfers and predicted results
  cipher_item_t item_q [$];
  cipher_res_t  cipher_exp_q [$];
  cipher_item_t next_item;
  cipher_res_t  want;

  int  queued_cnt   = 0;
  int  accepted_cnt = 0;
  int  err_cnt      = 0;
  int  idle_cycles  = 0;
  int  send_gap     = 0;
  int  stall_run    = 0;
  int  run_len;
  bit  send_calm    = 1'b0;
  bit  recv_calm    = 1'b0;
  bit  holdoff_done = 1'b0;

  keyword_substitution_cipher uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .char_in_i   (char_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .char_out_o  (char_out),
    .status_o    (status)
  );

  // Clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Letter index in the alphabet, -1 for any other byte
  function automatic int letter_index(logic [kwsc_pkg::CHAR_W-1:0] c, output bit lower);
    lower = 1'b0;
    if (c >= kwsc_pkg::UPPER_FIRST && c < kwsc_pkg::UPPER_FIRST + ALPHA)
      return int'(c - kwsc_pkg::UPPER_FIRST);
    lower = 1'b1;
    if (c >= kwsc_pkg::LOWER_FIRST && c < kwsc_pkg::LOWER_FIRST + ALPHA)
      return int'(c - kwsc_pkg::LOWER_FIRST);
    return -1;
  endfunction

  // Applies one action to the key state and returns the expected output
  function automatic cipher_res_t predict_cipher(logic [kwsc_pkg::ACT_W-1:0] act,
                                                 logic [kwsc_pkg::CHAR_W-1:0] ch);
    cipher_res_t                res;
    int                         idx;
    int                         nxt;
    bit                         lower;
    logic [kwsc_pkg::IDX_W-1:0] m;
    res.ch = ch;
    res.st = 1'b0;
    idx = letter_index(ch, lower);
    case (act)
      kwsc_pkg::ACT_CLEAR: begin
        taken      = '0;
        key_len    = 0;
        key_broken = 1'b0;
      end
      kwsc_pkg::ACT_KEY: begin
        if (idx < 0) begin
          key_broken = 1'b1;
        end else if (!taken[idx]) begin
          taken[idx] = 1'b1;
          if (key_len < ALPHA) begin
            fwd_map[key_len] = idx[kwsc_pkg::IDX_W-1:0];
            key_len++;
          end
        end
      end
      kwsc_pkg::ACT_DONE: begin
        if (key_broken) begin
          res.st = 1'b1;
          for (int i = 0; i < ALPHA; i++) begin
            fwd_map[i] = i[kwsc_pkg::IDX_W-1:0];
            inv_map[i] = i[kwsc_pkg::IDX_W-1:0];
          end
        end else begin
          // append the unused letters in ascending order, then invert
          nxt = 0;
          while (key_len < ALPHA) begin
            while (nxt < ALPHA && taken[nxt]) nxt++;
            if (nxt >= ALPHA) break;
            taken[nxt] = 1'b1;
            fwd_map[key_len] = nxt[kwsc_pkg::IDX_W-1:0];
            key_len++;
          end
          for (int i = 0; i < ALPHA; i++) begin
            if (fwd_map[i] < ALPHA) inv_map[fwd_map[i]] = i[kwsc_pkg::IDX_W-1:0];
          end
        end
      end
      kwsc_pkg::ACT_ENC, kwsc_pkg::ACT_DEC: begin
        if (idx >= 0) begin
          m = (act == kwsc_pkg::ACT_ENC) ? fwd_map[idx] : inv_map[idx];
          res.ch = (lower ? kwsc_pkg::LOWER_FIRST : kwsc_pkg::UPPER_FIRST) + m;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [kwsc_pkg::CHAR_W-1:0] rand_letter();
    logic [kwsc_pkg::CHAR_W-1:0] base;
    base = ($urandom_range(0, 1) != 0) ? kwsc_pkg::LOWER_FIRST : kwsc_pkg::UPPER_FIRST;
    return base + kwsc_pkg::CHAR_W'($urandom_range(0, ALPHA - 1));
  endfunction

  function automatic logic [kwsc_pkg::CHAR_W-1:0] rand_nonletter();
    logic [kwsc_pkg::CHAR_W-1:0] c;
    bit                          lower;
    do c = kwsc_pkg::CHAR_W'($urandom_range(0, 255)); while (letter_index(c, lower) >= 0);
    return c;
  endfunction

  // Text is mostly letters, the rest any byte
  function automatic logic [kwsc_pkg::CHAR_W-1:0] rand_text();
    if ($urandom_range(0, 4) != 0) return rand_letter();
    return kwsc_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic add_item(logic [kwsc_pkg::ACT_W-1:0] act, logic [kwsc_pkg::CHAR_W-1:0] ch);
    cipher_item_t it;
    it.act = act;
    it.ch  = ch;
    item_q.push_back(it);
    queued_cnt++;
  endtask

  // One key session: optional clear, key letters, key done, then text; or raw noise
  task automatic add_session();
    int                          n_key;
    int                          bad_at;
    int                          j;
    int                          tmp;
    int                          perm [ALPHA];
    bit                          full_key;
    logic [kwsc_pkg::CHAR_W-1:0] base;
    if ($urandom_range(0, 99) < 8) begin
      // raw noise, unknown actions included
      repeat ($urandom_range(3, 8))
        add_item(kwsc_pkg::ACT_W'($urandom_range(0, 7)),
                 kwsc_pkg::CHAR_W'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) != 0)
      add_item(kwsc_pkg::ACT_CLEAR, kwsc_pkg::CHAR_W'($urandom_range(0, 255)));
    full_key = ($urandom_range(0, 19) == 0);
    n_key    = full_key ? ALPHA : $urandom_range(0, 8);
    bad_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_key) : -1;
    for (int i = 0; i < ALPHA; i++) perm[i] = i;
    for (int i = ALPHA - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < n_key; i++) begin
      if (i == bad_at) add_item(kwsc_pkg::ACT_KEY, rand_nonletter());
      if (full_key) begin
        base = ($urandom_range(0, 1) != 0) ? kwsc_pkg::LOWER_FIRST : kwsc_pkg::UPPER_FIRST;
        add_item(kwsc_pkg::ACT_KEY, base + kwsc_pkg::CHAR_W'(perm[i]));
      end else begin
        add_item(kwsc_pkg::ACT_KEY, rand_letter());
      end
      // text while the key is only partly written
      if ($urandom_range(0, 14) == 0)
        add_item(($urandom_range(0, 1) != 0) ? kwsc_pkg::ACT_ENC : kwsc_pkg::ACT_DEC,
                 rand_text());
    end
    if (bad_at == n_key) add_item(kwsc_pkg::ACT_KEY, rand_nonletter());
    add_item(kwsc_pkg::ACT_DONE, kwsc_pkg::CHAR_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      add_item(kwsc_pkg::ACT_DONE, kwsc_pkg::CHAR_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 14) == 0)
      add_item(kwsc_pkg::ACT_KEY, kwsc_pkg::CHAR_W'($urandom_range(0, 255)));
    repeat ($urandom_range(4, 24))
      add_item(($urandom_range(0, 1) != 0) ? kwsc_pkg::ACT_ENC : kwsc_pkg::ACT_DEC,
               rand_text());
  endtask

  // Wait until everything queued has been accepted and answered
  task automatic drain();
    while (accepted_cnt != queued_cnt || cipher_exp_q.size() != 0) @(posedge clk_i);
  endtask

  // Input driver: one transfer per accepted edge, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      action   <= '0;
      char_in  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        cipher_exp_q.push_back(predict_cipher(action, char_in));
        accepted_cnt++;
      end
      if ($urandom_range(0, 299) == 0) send_calm <= !send_calm;
      if (in_valid && in_stall) begin
        // payload held while stalled
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (item_q.size() != 0) begin
        next_item = item_q.pop_front();
        in_valid  <= 1'b1;
        action    <= next_item.act;
        char_in   <= next_item.ch;
        send_gap  <= send_calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_exp_q.size() == 0) begin
          $display("%0t: output transfer with nothing expected: char %h status %b",
                   $time, char_out, status);
          err_cnt++;
        end else begin
          want = cipher_exp_q.pop_front();
          if (char_out !== want.ch) begin
            $display("%0t: char_out mismatch: expected %h actual %h",
                     $time, want.ch, char_out);
            err_cnt++;
          end
          if (status !== want.st) begin
            $display("%0t: status mismatch: expected %b actual %b",
                     $time, want.st, status);
            err_cnt++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) recv_calm <= !recv_calm;
      // one long hold-off so the block backs up into its input
      if (!holdoff_done && accepted_cnt >= HOLD_AT) begin
        holdoff_done <= 1'b1;
        out_stall    <= 1'b1;
        stall_run    <= HOLD_LEN - 1;
      end else if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run <= stall_run - 1;
      end else begin
        run_len = recv_calm ? 0 : pick_gap();
        if (run_len > 0) begin
          out_stall <= 1'b1;
          stall_run <= run_len - 1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    for (int i = 0; i < ALPHA; i++) begin
      fwd_map[i] = i[kwsc_pkg::IDX_W-1:0];
      inv_map[i] = i[kwsc_pkg::IDX_W-1:0];
    end
    taken      = '0;
    key_len    = 0;
    key_broken = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // identity tables after reset, bytes around both letter ranges
    add_item(kwsc_pkg::ACT_ENC, "A");
    add_item(kwsc_pkg::ACT_DEC, "z");
    add_item(kwsc_pkg::ACT_ENC, 8'h40);
    add_item(kwsc_pkg::ACT_ENC, 8'h5B);
    add_item(kwsc_pkg::ACT_DEC, 8'h60);
    add_item(kwsc_pkg::ACT_ENC, 8'h7B);
    add_item(kwsc_pkg::ACT_ENC, 8'h00);
    add_item(kwsc_pkg::ACT_DEC, 8'hFF);
    // unknown actions pass the byte through
    add_item(3'd5, "q");
    add_item(3'd6, 8'h80);
    add_item(3'd7, 8'h7F);
    // key with a repeat in the other case, text while entering it
    add_item(kwsc_pkg::ACT_CLEAR, 8'h00);
    add_item(kwsc_pkg::ACT_KEY, "Z");
    add_item(kwsc_pkg::ACT_KEY, "e");
    add_item(kwsc_pkg::ACT_KEY, "E");
    add_item(kwsc_pkg::ACT_ENC, "a");
    add_item(kwsc_pkg::ACT_KEY, "b");
    add_item(kwsc_pkg::ACT_DONE, 8'hFF);
    add_item(kwsc_pkg::ACT_ENC, "Z");
    add_item(kwsc_pkg::ACT_DEC, "y");
    // second key done, letters after done, then a bad key
    add_item(kwsc_pkg::ACT_DONE, 8'h00);
    add_item(kwsc_pkg::ACT_KEY, "q");
    add_item(kwsc_pkg::ACT_KEY, "1");
    add_item(kwsc_pkg::ACT_DONE, 8'h00);
    add_item(kwsc_pkg::ACT_ENC, "m");
    drain();

    while (queued_cnt < 450) add_session();
    drain();
    while (queued_cnt < 925) add_session();
    drain();

    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
